// File: src/smad_pkg.sv
// Shared types, widths and sequencer states for the sliding median and
// absolute-deviation block. No dependencies; compile first.
package smad_pkg;

  localparam int CFG_W  = 9;
  localparam int DATA_W = 32;
  localparam int COST_W = 40;

  typedef logic        [CFG_W-1:0]  cfg_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic        [COST_W-1:0] cost_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,   // wait for a sample beat
    ST_INS,    // walk the sorted store downward, shifting larger entries up
    ST_PUT,    // place the new sample at the bottom of the store
    ST_MED,    // read the median entry and the departing ring entry
    ST_LOAD,   // capture median and departing sample, start the scan
    ST_COST,   // scan: accumulate deviations and close the removal gap
    ST_DONE    // hand the result to the output register
  } state_t;

endpackage

// File: src/smad_if.sv
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on smad_pkg.
interface smad_in_if;
  import smad_pkg::*;
  logic  valid;
  logic  ready;
  data_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface smad_out_if;
  import smad_pkg::*;
  logic  valid;
  logic  ready;
  data_t median;
  cost_t cost;
  modport source (output valid, output median, output cost, input ready);
  modport sink   (input valid, input median, input cost, output ready);
endinterface

// File: src/sliding_median_abs_deviation.sv
// Top level: sliding-window lower median and sum of absolute deviations.
// Depends on smad_pkg, smad_if (smad_in_if, smad_out_if) and smad_dev_acc.
//
//   channel   | dir | handshake        | payload
//   ----------+-----+------------------+------------------------------
//   samples   | in  | valid/ready      | sample (signed 32)
//   results   | out | valid/ready      | median (signed 32), cost (40)
//   cfg       | in  | cfg_we, no wait  | cfg_wdata = window_size (9)
//
// The sorted store is walked one entry a cycle through its single read and
// single write port: insertion shifts each larger sorted entry up, and with
// the window full a deviation and removal scan over every window entry
// follows. Reset leaves the window empty with window_size 1; no clearing
// pass is needed. A result waiting in the output register lets the next
// sample in and stalls only the final hand-off.
module sliding_median_abs_deviation #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  smad_in_if.sink         samples,
  smad_out_if.source      results,
  input  logic            cfg_we,
  input  smad_pkg::cfg_t  cfg_wdata
);
  import smad_pkg::*;

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int WW = (CW > CFG_W) ? CW : CFG_W;

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;

  // Control state
  state_t          state, state_next;
  logic [CW-1:0]   win;
  logic [CW-1:0]   fill;
  logic [AW-1:0]   rp;
  logic            out_valid;

  // Working registers
  logic [AW-1:0]   cur;
  samp_t           x;
  samp_t           med;
  samp_t           old;
  logic            found;
  data_t           out_median;
  cost_t           out_cost;

  // Memories
  samp_t           sort_mem [WINDOW_MAX];
  samp_t           ring_mem [WINDOW_MAX];
  samp_t           sort_rdata;
  samp_t           ring_rdata;

  // Sequencer strobes
  logic            accept;
  logic            s_re, s_we, r_re;
  logic [AW-1:0]   s_raddr, s_waddr;
  samp_t           s_wdata;
  logic            acc_clr, acc_en;
  logic            ins_done, out_load;
  logic            gt, match, last, full;
  logic [CW-1:0]   fill_inc;
  logic [AW-1:0]   rp_next;
  logic [AW-1:0]   med_idx;
  logic [WW-1:0]   ws_ext;
  logic [CW-1:0]   win_cfg;
  samp_t           samp_in;
  cost_t           acc;

  // Decode the sample and the window register
  assign samp_in  = samp_t'(samples.sample[SAMPLE_BITS-1:0]);
  assign ws_ext   = WW'(cfg_wdata);
  assign win_cfg  = (ws_ext == '0) ? CW'(1) :
                    (ws_ext > WW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(ws_ext);

  assign fill_inc = fill + CW'(1);
  assign full     = (fill_inc == win);
  assign rp_next  = (CW'(rp) + CW'(1) == win) ? '0 : rp + AW'(1);
  assign med_idx  = AW'((win - CW'(1)) >> 1);
  assign gt       = (sort_rdata > x);
  assign match    = !found && (sort_rdata == old);
  assign last     = (CW'(cur) == win - CW'(1));

  assign samples.ready  = (state == ST_IDLE);
  assign accept         = samples.valid && samples.ready;

  assign results.valid  = out_valid;
  assign results.median = out_median;
  assign results.cost   = out_cost;

  // Next state and strobes
  always_comb begin
    state_next = state;
    s_re       = 1'b0;
    s_raddr    = '0;
    s_we       = 1'b0;
    s_waddr    = '0;
    s_wdata    = x;
    r_re       = 1'b0;
    acc_clr    = 1'b0;
    acc_en     = 1'b0;
    ins_done   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (fill == '0) begin
            state_next = ST_PUT;
          end else begin
            s_re       = 1'b1;
            s_raddr    = AW'(fill - CW'(1));
            state_next = ST_INS;
          end
        end
      end
      ST_INS: begin
        s_we    = 1'b1;
        s_waddr = cur + AW'(1);
        s_wdata = gt ? sort_rdata : x;
        if (!gt) begin
          ins_done   = 1'b1;
          state_next = full ? ST_MED : ST_IDLE;
        end else if (cur == '0) begin
          state_next = ST_PUT;
        end else begin
          s_re    = 1'b1;
          s_raddr = cur - AW'(1);
        end
      end
      ST_PUT: begin
        s_we       = 1'b1;
        s_waddr    = '0;
        s_wdata    = x;
        ins_done   = 1'b1;
        state_next = full ? ST_MED : ST_IDLE;
      end
      ST_MED: begin
        s_re       = 1'b1;
        s_raddr    = med_idx;
        r_re       = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        s_re       = 1'b1;
        s_raddr    = '0;
        acc_clr    = 1'b1;
        state_next = ST_COST;
      end
      ST_COST: begin
        acc_en  = 1'b1;
        s_we    = found;
        s_waddr = cur - AW'(1);
        s_wdata = sort_rdata;
        if (last) begin
          state_next = ST_DONE;
        end else begin
          s_re    = 1'b1;
          s_raddr = cur + AW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid || results.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold control state; clear the window on a register write
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      win       <= CW'(1);
      fill      <= '0;
      rp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        win  <= win_cfg;
        fill <= '0;
        rp   <= '0;
      end
      if (accept) begin
        rp <= rp_next;
      end
      if (ins_done && !full) begin
        fill <= fill_inc;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Advance the working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x   <= samp_in;
      cur <= AW'(fill - CW'(1));
    end
    if (state == ST_INS && gt && cur != '0) begin
      cur <= cur - AW'(1);
    end
    if (state == ST_LOAD) begin
      med   <= sort_rdata;
      old   <= ring_rdata;
      cur   <= '0;
      found <= 1'b0;
    end
    if (state == ST_COST) begin
      if (match) begin
        found <= 1'b1;
      end
      if (!last) begin
        cur <= cur + AW'(1);
      end
    end
    if (out_load) begin
      out_median <= DATA_W'(med);
      out_cost   <= acc;
    end
  end

  // Sorted store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (s_we) begin
      sort_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      sort_rdata <= sort_mem[s_raddr];
    end
  end

  // Arrival ring: write on accept, read the departing slot
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_mem[rp] <= samp_in;
    end
    if (r_re) begin
      ring_rdata <= ring_mem[rp];
    end
  end

  smad_dev_acc #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dev_acc (
    .clk    (clk),
    .clr    (acc_clr),
    .en     (acc_en),
    .d      (sort_rdata),
    .center (med),
    .acc    (acc)
  );

endmodule

// File: src/smad_dev_acc.sv
// Deviation unit: accumulates |d - center| into a wrapping cost sum.
// Depends on smad_pkg.
module smad_dev_acc #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          clr,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] d,
  input  logic signed [SAMPLE_BITS-1:0] center,
  output smad_pkg::cost_t               acc
);
  import smad_pkg::*;

  logic [SAMPLE_BITS:0] d_ext;
  logic [SAMPLE_BITS:0] c_ext;
  logic [SAMPLE_BITS:0] mag;

  // Form the magnitude of the difference with one extra bit of headroom
  assign d_ext = {d[SAMPLE_BITS-1], d};
  assign c_ext = {center[SAMPLE_BITS-1], center};
  assign mag   = (d >= center) ? (d_ext - c_ext) : (c_ext - d_ext);

  // Clear at the start of a scan, add one entry per cycle
  always_ff @(posedge clk) begin
    if (clr) begin
      acc <= '0;
    end else if (en) begin
      acc <= acc + COST_W'(mag);
    end
  end

endmodule

// File: tb/sliding_median_abs_deviation_tb.sv
// Self-checking bench for sliding_median_abs_deviation: it drives sample beats
// through a directed table and then random window phases, and checks each result beat.
// Depends on smad_pkg, smad_if and the RTL top level.
module sliding_median_abs_deviation_tb;
  import smad_pkg::*;

  localparam int WINDOW_LIMIT  = 256;
  localparam int SETTLE_CYCLES = 2 * WINDOW_LIMIT + 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int REPORT_LIMIT  = 50;

  localparam data_t SAMPLE_MIN = data_t'(32'h8000_0000);
  localparam data_t SAMPLE_MAX = data_t'(32'h7FFF_FFFF);

  typedef enum logic { ROW_CFG, ROW_SAMPLE } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [31:0] value;
    bit          typed;
    data_t       exp_median;
    cost_t       exp_cost;
  } stim_row_t;

  typedef struct {
    data_t median;
    cost_t cost;
  } window_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cfg_t cfg_wdata;

  smad_in_if  sample_bus ();
  smad_out_if result_bus ();

  sliding_median_abs_deviation u_top (
    .clk       (clk),
    .rst       (rst),
    .samples   (sample_bus),
    .results   (result_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Window model: arrival ring plus an ascending copy of the live samples
  int unsigned    win_len;
  int unsigned    ring_pos;
  data_t          arrival[WINDOW_LIMIT];
  data_t          ordered[$];
  window_result_t expected_results[$];

  stim_row_t directed_rows[$];
  window_result_t head;

  int err_count = 0;
  int samples_sent;
  int results_seen = 0;
  int settings_count;
  int burst_left;
  int unsigned cycle_count = 0;
  bit hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results still due", $time, cycle_count,
               expected_results.size());
      $display("sliding_median_abs_deviation test failed");
      $finish;
    end
  end

  // Load a new window length; zero acts as one, anything above the store depth saturates
  function automatic void set_window(cfg_t v);
    if (v == 0) win_len = 1;
    else if (v > WINDOW_LIMIT) win_len = WINDOW_LIMIT;
    else win_len = 32'(v);
    ring_pos = 0;
    ordered.delete();
  endfunction

  // Take one sample into the window; report the lower median and deviation sum when full
  function automatic bit predict_window(input data_t x, output data_t med, output cost_t dev);
    int unsigned slot;
    longint acc;
    longint d;
    data_t leaving;
    slot = ordered.size();
    for (int i = 0; i < ordered.size(); i++) begin
      if (ordered[i] > x) begin
        slot = i;
        break;
      end
    end
    ordered.insert(slot, x);
    arrival[ring_pos] = x;
    ring_pos = (ring_pos + 1) % win_len;
    med = '0;
    dev = '0;
    if (ordered.size() < win_len) return 1'b0;
    med = ordered[(ordered.size() + 1) / 2 - 1];
    acc = 0;
    foreach (ordered[i]) begin
      d = longint'(ordered[i]) - longint'(med);
      acc += (d < 0) ? -d : d;
    end
    dev = cost_t'(acc);
    // Drop one copy of the oldest sample
    leaving = arrival[ring_pos];
    for (int i = 0; i < ordered.size(); i++) begin
      if (ordered[i] == leaving) begin
        ordered.delete(i);
        break;
      end
    end
    return 1'b1;
  endfunction

  function automatic data_t rand_sample();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: return SAMPLE_MIN;
        1: return SAMPLE_MAX;
        2: return data_t'(0);
        default: return data_t'(-1);
      endcase
    end
    if (pick < 5) return data_t'(int'($urandom_range(0, 16)) - 8);
    return data_t'($urandom);
  endfunction

  function automatic void add_cfg(cfg_t v);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.value = 32'(v);
    row.typed = 1'b0;
    row.exp_median = '0;
    row.exp_cost = '0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_sample(logic [31:0] v, bit typed, data_t m, cost_t c);
    stim_row_t row;
    row.kind = ROW_SAMPLE;
    row.value = v;
    row.typed = typed;
    row.exp_median = m;
    row.exp_cost = c;
    directed_rows.push_back(row);
  endfunction

  // Offer one sample beat, idling between bursts, and record what it should produce
  task automatic offer_sample(input data_t v, input bit typed, input data_t m, input cost_t c);
    int gap;
    data_t med;
    cost_t dev;
    window_result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        sample_bus.sample <= data_t'($urandom);
      end
    end
    burst_left--;
    @(negedge clk);
    sample_bus.valid <= 1'b1;
    sample_bus.sample <= v;
    do @(posedge clk); while (!sample_bus.ready);
    samples_sent++;
    if (predict_window(v, med, dev)) begin
      r.median = typed ? m : med;
      r.cost = typed ? c : dev;
      expected_results.push_back(r);
    end
  endtask

  // Hold input, let every result drain, then let the block finish any silent beat
  task automatic drain_idle();
    @(negedge clk);
    sample_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input cfg_t v);
    drain_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    set_window(v);
    settings_count++;
  endtask

  // Result side: stall on a repeating pattern, with one long hold-off on request
  initial begin
    int stall_phase;
    int hold_left;
    bit hold_taken;
    result_bus.ready = 1'b0;
    stall_phase = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        stall_phase = (stall_phase + 1) % 48;
        if (stall_phase < 16) result_bus.ready <= 1'b1;
        else if (stall_phase < 32) result_bus.ready <= ($urandom_range(0, 2) != 0);
        else result_bus.ready <= ($urandom_range(0, 7) == 0);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("%0t: unexpected result beat: expected none, actual median %0d cost %0d",
                   $time, result_bus.median, result_bus.cost);
      end else begin
        head = expected_results.pop_front();
        if (result_bus.median !== head.median) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("%0t: median mismatch: expected %0d actual %0d", $time, head.median,
                     result_bus.median);
        end
        if (result_bus.cost !== head.cost) begin
          err_count++;
          if (err_count <= REPORT_LIMIT)
            $display("%0t: cost mismatch: expected %0d actual %0d", $time, head.cost,
                     result_bus.cost);
        end
      end
    end
  end

  initial begin
    cfg_t phase_cfg[$];
    int phase_items[$];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sample_bus.valid = 1'b0;
    sample_bus.sample = '0;
    samples_sent = 0;
    settings_count = 0;
    burst_left = 0;
    hold_req = 1'b0;
    set_window(cfg_t'(1));

    // Directed rows: extremes at window one, short windows, ties, saturation
    add_sample(32'h0000_0000, 1'b1, data_t'(0), cost_t'(0));
    add_sample(32'h8000_0000, 1'b1, SAMPLE_MIN, cost_t'(0));
    add_sample(32'h7FFF_FFFF, 1'b1, SAMPLE_MAX, cost_t'(0));
    add_sample(32'hFFFF_FFFF, 1'b1, data_t'(-1), cost_t'(0));
    add_sample(32'h5555_5555, 1'b1, data_t'(32'h5555_5555), cost_t'(0));
    add_cfg(cfg_t'(0));
    add_sample(32'hAAAA_AAAA, 1'b1, data_t'(32'hAAAA_AAAA), cost_t'(0));
    add_cfg(cfg_t'(2));
    add_sample(32'd5, 1'b0, '0, '0);
    add_sample(32'd9, 1'b1, data_t'(5), cost_t'(4));
    add_sample(32'd1, 1'b1, data_t'(1), cost_t'(8));
    add_cfg(cfg_t'(3));
    add_sample(32'h8000_0000, 1'b0, '0, '0);
    add_sample(32'h7FFF_FFFF, 1'b0, '0, '0);
    add_sample(32'h0000_0000, 1'b1, data_t'(0), cost_t'(40'hFFFF_FFFF));
    add_sample(32'h0000_0000, 1'b1, data_t'(0), cost_t'(40'h7FFF_FFFF));
    add_cfg(cfg_t'(4));
    add_sample(32'd7, 1'b0, '0, '0);
    add_sample(32'd7, 1'b0, '0, '0);
    add_sample(32'd7, 1'b0, '0, '0);
    add_sample(32'd7, 1'b1, data_t'(7), cost_t'(0));
    add_sample(32'd7, 1'b1, data_t'(7), cost_t'(0));
    add_sample(32'd3, 1'b0, '0, '0);
    add_sample(32'd20, 1'b0, '0, '0);
    add_cfg(cfg_t'(257));
    add_sample(32'd11, 1'b0, '0, '0);
    add_sample(32'hFFFF_FFF5, 1'b0, '0, '0);
    add_sample(32'd0, 1'b0, '0, '0);
    add_cfg(cfg_t'(1));
    add_sample(32'd123, 1'b1, data_t'(123), cost_t'(0));

    // Random phases: mostly short windows, a few at full depth
    phase_cfg.push_back(cfg_t'(5));   phase_items.push_back(120);
    phase_cfg.push_back(cfg_t'(1));   phase_items.push_back(100);
    phase_cfg.push_back(cfg_t'(511)); phase_items.push_back(300);
    phase_cfg.push_back(cfg_t'(2));   phase_items.push_back(90);
    repeat (6) begin
      phase_cfg.push_back(cfg_t'($urandom_range(3, 20)));
      phase_items.push_back(90);
    end
    phase_cfg.push_back(cfg_t'(256)); phase_items.push_back(280);
    phase_cfg.push_back(cfg_t'(64));  phase_items.push_back(100);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG)
        write_window(directed_rows[r].value[CFG_W-1:0]);
      else
        offer_sample(data_t'(directed_rows[r].value), directed_rows[r].typed,
                     directed_rows[r].exp_median, directed_rows[r].exp_cost);
    end

    foreach (phase_cfg[p]) begin
      write_window(phase_cfg[p]);
      for (int i = 0; i < phase_items[p]; i++) begin
        // Stall the result side for a long stretch while beats keep coming
        if (p == 0 && i == 20) hold_req = 1'b1;
        offer_sample(rand_sample(), 1'b0, '0, '0);
      end
    end

    drain_idle();
    $display("Ran %0d sample beats over %0d window settings; %0d result beats checked.",
             samples_sent, settings_count, results_seen);
    if (err_count == 0)
      $display("sliding_median_abs_deviation test passed");
    else
      $display("sliding_median_abs_deviation test failed");
    $finish;
  end

endmodule

// File: sim.f
src/smad_pkg.sv
src/smad_if.sv
src/smad_dev_acc.sv
src/sliding_median_abs_deviation.sv
tb/sliding_median_abs_deviation_tb.sv
